>>> sv/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg: shared types for the sequence replay window
// Result status codes, controller states and the probe that walks the cells.
// ----------------------------------------------------------------------------
package srw_pkg;

  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned WINDOW_W = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_APPENDED  = 2'd0,
    ST_REPLACED  = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_TOO_OLD   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Probe handed from cell to cell during a scan
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             dup;
    logic [SEQ_W-1:0] min_val;
  } probe_t;

endpackage

>>> sv/sequence_replay_window.sv
// ----------------------------------------------------------------------------
// sequence_replay_window: anti-replay check on received sequence numbers
// Keeps up to window_size accepted numbers and flags duplicates and stale ones.
// ----------------------------------------------------------------------------
// Each item is first taken from the input, then scanned while a probe walks
// the chain of history cells checking for a duplicate and tracking the
// smallest entry, and then committed: the write-back is done and the result
// register loaded. The next item is taken as soon as the result is loaded; a
// result left waiting on out_ready holds the following item in its commit
// step. Entries are only read once written, so the history needs no clearing
// after reset. A window_size of zero acts as one, and values above
// HISTORY_DEPTH saturate.
// ----------------------------------------------------------------------------
module sequence_replay_window import srw_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WINDOW_W-1:0] cfg_window_size,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SEQ_W-1:0]    in_sequence_number,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic [1:0]          out_status
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

  state_t              state_r, state_nxt;
  logic [WINDOW_W-1:0] window_r;
  logic [CNT_W-1:0]    fill_r;
  logic [IDX_W-1:0]    cnt_r;
  logic [SEQ_W-1:0]    seq_r;
  logic                out_valid_r;
  logic                accepted_r;
  status_t             status_r;

  logic                commit;
  logic                wr;
  logic [IDX_W-1:0]    wr_idx;
  logic                fill_inc;
  status_t             status_nxt;
  logic [CMP_W-1:0]    eff_size;
  logic                has_room;

  probe_t              probe  [0:HISTORY_DEPTH];
  logic [IDX_W-1:0]    min_idx[0:HISTORY_DEPTH];

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  // Clamp the window to 1..HISTORY_DEPTH
  always_comb begin
    eff_size = CMP_W'(window_r);
    if (window_r == '0) begin
      eff_size = CMP_W'(1);
    end else if (CMP_W'(window_r) > CMP_W'(HISTORY_DEPTH)) begin
      eff_size = CMP_W'(HISTORY_DEPTH);
    end
  end
  assign has_room = CMP_W'(fill_r) < eff_size;

  // Launch probe into the first cell
  assign probe[0]   = '{seq: seq_r, dup: 1'b0, min_val: {SEQ_W{1'b1}}};
  assign min_idx[0] = '0;

  // Chain of history cells
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic cell_active;
    assign cell_active = CNT_W'(i) < fill_r;

    srw_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .active      (cell_active),
      .wr_en       (wr && (wr_idx == IDX_W'(i))),
      .wr_data     (seq_r),
      .probe_in    (probe[i]),
      .min_idx_in  (min_idx[i]),
      .probe_out   (probe[i+1]),
      .min_idx_out (min_idx[i+1])
    );
  end

  // Next state, decision and write-back control
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    commit     = 1'b0;
    wr         = 1'b0;
    wr_idx     = fill_r[IDX_W-1:0];
    fill_inc   = 1'b0;
    status_nxt = ST_DUPLICATE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == IDX_W'(HISTORY_DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
          priority if (probe[HISTORY_DEPTH].dup) begin
            status_nxt = ST_DUPLICATE;
          end else if (has_room) begin
            status_nxt = ST_APPENDED;
            wr         = 1'b1;
            fill_inc   = 1'b1;
          end else if (seq_r < probe[HISTORY_DEPTH].min_val) begin
            status_nxt = ST_TOO_OLD;
          end else begin
            status_nxt = ST_REPLACED;
            wr         = 1'b1;
            wr_idx     = min_idx[HISTORY_DEPTH];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WINDOW_W'(16);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_size;
      end
      if (fill_inc) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the sequence number and the result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seq_r <= in_sequence_number;
    end
    if (commit) begin
      status_r   <= status_nxt;
      accepted_r <= (status_nxt == ST_APPENDED) || (status_nxt == ST_REPLACED);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = accepted_r;
  assign out_status   = status_r;

endmodule

>>> sv/srw_cell.sv
// ----------------------------------------------------------------------------
// srw_cell: one history entry of the replay window
// Holds one accepted sequence number, checks the passing probe against it for
// a duplicate and for a new minimum, and registers the probe for the next cell.
// ----------------------------------------------------------------------------
module srw_cell import srw_pkg::*; #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 active,
  input  logic                 wr_en,
  input  logic [SEQ_W-1:0]     wr_data,
  input  probe_t               probe_in,
  input  logic [IDX_W-1:0]     min_idx_in,
  output probe_t               probe_out,
  output logic [IDX_W-1:0]     min_idx_out
);

  logic [SEQ_W-1:0] entry_r;
  probe_t           probe_r;
  probe_t           probe_nxt;
  logic [IDX_W-1:0] min_idx_r;
  logic [IDX_W-1:0] min_idx_nxt;

  // Store a new entry on write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  // Compare the probe with this entry; later cells win ties on the minimum
  always_comb begin
    probe_nxt   = probe_in;
    min_idx_nxt = min_idx_in;
    if (active) begin
      probe_nxt.dup = probe_in.dup | (entry_r == probe_in.seq);
      if (entry_r <= probe_in.min_val) begin
        probe_nxt.min_val = entry_r;
        min_idx_nxt       = IDX_W'(CELL_IDX);
      end
    end
  end

  // Hand the probe to the next cell
  always_ff @(posedge clk) begin
    probe_r   <= probe_nxt;
    min_idx_r <= min_idx_nxt;
  end

  assign probe_out   = probe_r;
  assign min_idx_out = min_idx_r;

endmodule
